// File: rtl/gncm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncm_pkg
// Shared types and constants of the greedy nearest color match core: opcodes,
// configuration register indexes, field widths and the distance limit.
// ----------------------------------------------------------------------------
package gncm_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] cfg_index_t;

	localparam opcode_t OP_LOAD  = 2'd0;
	localparam opcode_t OP_MATCH = 2'd1;
	localparam opcode_t OP_CLEAR = 2'd2;

	localparam cfg_index_t CFG_IMAGE_WIDTH = 2'd0;
	localparam cfg_index_t CFG_PIXEL_COUNT = 2'd1;
	localparam cfg_index_t CFG_ALLOW_REUSE = 2'd2;

	localparam int CHAN_W   = 8;
	localparam int COLOR_W  = 3 * CHAN_W;
	localparam int SQ_W     = 2 * CHAN_W;
	localparam int DIST_W   = 18;
	localparam int TAG_W    = 16;
	localparam int MX_W     = 10;
	localparam int MY_W     = 16;
	localparam int IWIDTH_W = 11;
	localparam int PCOUNT_W = 17;
	localparam int CFG_W    = 17;

	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
	localparam logic [DIST_W-1:0] DIST_LIMIT = 18'd195075;

	localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RST = 11'd320;
	localparam logic [PCOUNT_W-1:0] PIXEL_COUNT_RST = 17'd65536;

endpackage

`default_nettype wire

// File: rtl/greedy_nearest_color_match_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_nearest_color_match_core
// Loads candidate pixels and answers match queries with the nearest unused
// candidate (any candidate when reuse is on) by squared RGB distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall) carry an opcode and a pixel. A load beat
//   writes one candidate. A clear beat sweeps all MAX_PIXELS entries of the
//   used-mark memory, one entry a cycle. A match beat scans candidates
//   0 .. pixel_count-1 (capped at MAX_PIXELS) through one shared distance
//   unit, one candidate a cycle, and produces one result beat; the next
//   input beat is taken once that result is loaded into the output register.
//   The scan rate is set by the single read port of the candidate store.
//   in_stall stays high while a clear or a scan runs.
//   Result beats (out_valid/out_stall) leave through an output register, so
//   the next input beat is taken while a result still waits. A finished scan
//   holds until the previous result has been taken.
//   Configuration writes (cfg_valid/cfg_ready) are always taken; write them
//   only while the block is idle.
//   After reset the used-mark memory is cleared by a sweep of all MAX_PIXELS
//   entries before the first input beat is taken.
// ----------------------------------------------------------------------------
module greedy_nearest_color_match_core
	import gncm_pkg::*;
#(
	parameter int MAX_PIXELS = 65536,
	parameter int MAX_WIDTH  = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          opcode,
	input  wire logic [TAG_W-1:0]    pixel_index,
	input  wire logic [CHAN_W-1:0]   red,
	input  wire logic [CHAN_W-1:0]   green,
	input  wire logic [CHAN_W-1:0]   blue,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [TAG_W-1:0]         reference_tag,
	output logic                     match_found,
	output logic [TAG_W-1:0]         match_index,
	output logic [MX_W-1:0]          match_x,
	output logic [MY_W-1:0]          match_y,
	output logic [DIST_W-1:0]        distance_squared,
	// configuration channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	localparam int AW = $clog2(MAX_PIXELS);
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	// configuration
	logic [IWIDTH_W-1:0] image_width_q;
	logic [PCOUNT_W-1:0] pixel_count_q;
	logic                allow_reuse_q;

	// sequencer
	logic [1:0]        state_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic [WW-1:0]     width_q;
	logic [XW-1:0]     x_q;
	logic [AW-1:0]     y_q;
	logic [CHAN_W-1:0] ref_r_q, ref_g_q, ref_b_q;
	logic [TAG_W-1:0]  tag_q;

	// scan pipeline
	logic              valid_s1;
	logic [AW-1:0]     idx_s1;
	logic [XW-1:0]     x_s1;
	logic [AW-1:0]     y_s1;
	logic              valid_s2;
	logic [AW-1:0]     idx_s2;
	logic [XW-1:0]     x_s2;
	logic [AW-1:0]     y_s2;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;

	// running best
	logic              found_q;
	logic [DIST_W-1:0] best_q;
	logic [AW-1:0]     best_idx_q;
	logic [XW-1:0]     best_x_q;
	logic [AW-1:0]     best_y_q;

	// result register
	logic              out_valid_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              out_found_q;
	logic [TAG_W-1:0]  out_index_q;
	logic [MX_W-1:0]   out_x_q;
	logic [MY_W-1:0]   out_y_q;
	logic [DIST_W-1:0] out_dist_q;

	logic              in_acc;
	logic              issue;
	logic              scan_done;
	logic              x_last;
	logic              finish_go;
	logic [31:0]       load_addr_w;
	logic              load_we;
	logic [31:0]       count_w;
	logic [31:0]       width_w;
	logic [COLOR_W-1:0] cand_rd;
	logic              used_rd;
	logic              used_we;
	logic [AW-1:0]     used_waddr;
	logic              used_wdata;
	logic [CHAN_W-1:0] d_r, d_g, d_b;
	logic [DIST_W-1:0] dist_s2;
	logic              elig_s1;
	logic              elig_s2;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;

	assign load_addr_w = 32'(pixel_index);
	assign load_we     = in_acc && (opcode == OP_LOAD) && (load_addr_w < 32'(MAX_PIXELS));

	assign count_w = (32'(pixel_count_q) > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS)
	                                                       : 32'(pixel_count_q);
	always_comb begin
		if (image_width_q == '0) begin
			width_w = 32'd1;
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			width_w = 32'(MAX_WIDTH);
		end else begin
			width_w = 32'(image_width_q);
		end
	end

	assign issue     = (state_q == ST_SCAN) && (idx_q < count_q);
	assign scan_done = (state_q == ST_SCAN) && (idx_q == count_q) && !valid_s1 && !valid_s2;
	assign x_last    = (32'(x_q) + 32'd1) == 32'(width_q);
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// mark the winner on the way out, or sweep during a clear
	assign used_we    = (state_q == ST_CLEAR) || (finish_go && found_q && !allow_reuse_q);
	assign used_waddr = (state_q == ST_CLEAR) ? idx_q[AW-1:0] : best_idx_q;
	assign used_wdata = (state_q != ST_CLEAR);

	gncm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (MAX_PIXELS)
	) u_cand_ram (
		.clk     (clk),
		.wr_en   (load_we),
		.wr_addr (load_addr_w[AW-1:0]),
		.wr_data ({red, green, blue}),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (cand_rd)
	);

	gncm_ram #(
		.WIDTH (1),
		.DEPTH (MAX_PIXELS)
	) u_used_ram (
		.clk     (clk),
		.wr_en   (used_we),
		.wr_addr (used_waddr),
		.wr_data (used_wdata),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (used_rd)
	);

	// shared distance unit: absolute differences, squares, then sum
	assign d_r = (ref_r_q > cand_rd[23:16]) ? (ref_r_q - cand_rd[23:16])
	                                        : (cand_rd[23:16] - ref_r_q);
	assign d_g = (ref_g_q > cand_rd[15:8]) ? (ref_g_q - cand_rd[15:8])
	                                       : (cand_rd[15:8] - ref_g_q);
	assign d_b = (ref_b_q > cand_rd[7:0]) ? (ref_b_q - cand_rd[7:0])
	                                      : (cand_rd[7:0] - ref_b_q);
	assign elig_s1 = valid_s1 && (allow_reuse_q || !used_rd);
	assign dist_s2 = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			pixel_count_q <= PIXEL_COUNT_RST;
			allow_reuse_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: image_width_q <= cfg_data[IWIDTH_W-1:0];
				CFG_PIXEL_COUNT: pixel_count_q <= cfg_data[PCOUNT_W-1:0];
				CFG_ALLOW_REUSE: allow_reuse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			found_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			// load a new result beat, or drop the old one once it is taken
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == CW'(MAX_PIXELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						case (opcode)
							OP_MATCH: begin
								found_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							OP_CLEAR: state_q <= ST_CLEAR;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (valid_s2 && elig_s2 && (dist_s2 < best_q)) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && (opcode == OP_MATCH)) begin
			ref_r_q    <= red;
			ref_g_q    <= green;
			ref_b_q    <= blue;
			tag_q      <= pixel_index;
			count_q    <= CW'(count_w);
			width_q    <= WW'(width_w);
			x_q        <= '0;
			y_q        <= '0;
			best_q     <= DIST_LIMIT;
			best_idx_q <= '0;
			best_x_q   <= '0;
			best_y_q   <= '0;
		end else begin
			if (issue) begin
				// advance column and row along with the scan address
				if (x_last) begin
					x_q <= '0;
					y_q <= y_q + AW'(1);
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
			if (valid_s2 && elig_s2 && (dist_s2 < best_q)) begin
				best_q     <= dist_s2;
				best_idx_q <= idx_s2;
				best_x_q   <= x_s2;
				best_y_q   <= y_s2;
			end
		end

		idx_s1  <= idx_q[AW-1:0];
		x_s1    <= x_q;
		y_s1    <= y_q;
		idx_s2  <= idx_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		elig_s2 <= elig_s1;
		sq_r_s2 <= SQ_W'(d_r) * SQ_W'(d_r);
		sq_g_s2 <= SQ_W'(d_g) * SQ_W'(d_g);
		sq_b_s2 <= SQ_W'(d_b) * SQ_W'(d_b);

		if (finish_go) begin
			out_tag_q   <= tag_q;
			out_found_q <= found_q;
			out_index_q <= TAG_W'(best_idx_q);
			out_x_q     <= MX_W'(best_x_q);
			out_y_q     <= MY_W'(best_y_q);
			out_dist_q  <= best_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign reference_tag    = out_tag_q;
	assign match_found      = out_found_q;
	assign match_index      = out_index_q;
	assign match_x          = out_x_q;
	assign match_y          = out_y_q;
	assign distance_squared = out_dist_q;

endmodule

`default_nettype wire

// File: rtl/gncm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gncm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gncm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy nearest color match core. It loads the
// scanned part of the candidate store first, then runs directed queries for
// ties, reuse, cleared marks, empty scans, the width limits and a result
// hold-off. After that come randomized phases under random settings. A local
// model of the store, the used marks and the registers predicts each result
// beat, and every beat is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
	import gncm_pkg::*;

	localparam int MAX_PIXELS     = 65536;
	localparam int MAX_WIDTH      = 1024;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int PRELOAD        = 32;

	localparam opcode_t OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              found;
		logic [TAG_W-1:0]  index;
		logic [MX_W-1:0]   x;
		logic [MY_W-1:0]   y;
		logic [DIST_W-1:0] sq_dist;
	} match_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          opcode;
	logic [TAG_W-1:0]    pixel_index;
	logic [CHAN_W-1:0]   red;
	logic [CHAN_W-1:0]   green;
	logic [CHAN_W-1:0]   blue;
	logic                out_valid;
	logic                out_stall;
	logic [TAG_W-1:0]    reference_tag;
	logic                match_found;
	logic [TAG_W-1:0]    match_index;
	logic [MX_W-1:0]     match_x;
	logic [MY_W-1:0]     match_y;
	logic [DIST_W-1:0]   distance_squared;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	// local copy of the block state
	logic [COLOR_W-1:0]  cand_mem [0:MAX_PIXELS-1];
	bit                  used_mem [0:MAX_PIXELS-1];
	logic [IWIDTH_W-1:0] width_q;
	logic [PCOUNT_W-1:0] count_q;
	logic                reuse_q;

	match_result_t       pending_matches [$];

	bit                  tx_pace;
	bit                  rx_pace;
	int unsigned         long_hold;
	longint unsigned     cyc;
	longint unsigned     clear_cyc;
	int unsigned         quiet_cycles;
	int unsigned         err_count;
	int unsigned         n_items;
	int unsigned         n_results;
	int unsigned         n_found;

	greedy_nearest_color_match_core #(
		.MAX_PIXELS(MAX_PIXELS),
		.MAX_WIDTH (MAX_WIDTH)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.pixel_index     (pixel_index),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.reference_tag   (reference_tag),
		.match_found     (match_found),
		.match_index     (match_index),
		.match_x         (match_x),
		.match_y         (match_y),
		.distance_squared(distance_squared),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned rgb_dist2(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
		int dr;
		int dg;
		int db;
		dr = int'(a[23:16]) - int'(b[23:16]);
		dg = int'(a[15:8]) - int'(b[15:8]);
		db = int'(a[7:0]) - int'(b[7:0]);
		return dr * dr + dg * dg + db * db;
	endfunction

	// Scan the local store the way the core does and queue the result beat.
	function automatic void predict_nearest(logic [TAG_W-1:0] tag, logic [COLOR_W-1:0] rgb);
		int unsigned   span;
		int unsigned   w;
		int unsigned   best;
		int unsigned   best_i;
		int unsigned   d;
		bit            hit;
		match_result_t res;
		span = (count_q > MAX_PIXELS) ? MAX_PIXELS : count_q;
		w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
		best = DIST_LIMIT;
		best_i = 0;
		hit = 1'b0;
		for (int unsigned i = 0; i < span; i++) begin
			if (!reuse_q && used_mem[i])
				continue;
			d = rgb_dist2(rgb, cand_mem[i]);
			if (d < best) begin
				best = d;
				best_i = i;
				hit = 1'b1;
			end
		end
		if (hit && !reuse_q)
			used_mem[best_i] = 1'b1;
		res.tag     = tag;
		res.found   = hit;
		res.index   = hit ? best_i[TAG_W-1:0] : '0;
		res.x       = hit ? MX_W'(best_i % w) : '0;
		res.y       = hit ? MY_W'(best_i / w) : '0;
		res.sq_dist = hit ? best[DIST_W-1:0] : DIST_LIMIT;
		pending_matches = {pending_matches, res};
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	function automatic logic [CHAN_W-1:0] jitter(logic [CHAN_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CHAN_W-1:0];
	endfunction

	// Offer one input beat and hold it until the core takes it. Valid stays
	// high afterwards so that a back-to-back beat needs no toggle.
	task automatic send_item(opcode_t op, logic [TAG_W-1:0] idx,
			logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		int unsigned gap;
		gap = tx_pace ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		pixel_index <= idx;
		red         <= r;
		green       <= g;
		blue        <= b;
		do @(posedge clk); while (in_stall);
		n_items++;
		case (op)
			OP_LOAD: cand_mem[idx] = {r, g, b};
			OP_MATCH: predict_nearest(idx, {r, g, b});
			OP_CLEAR: begin
				foreach (used_mem[i])
					used_mem[i] = 1'b0;
				clear_cyc = cyc;
			end
			default: ;
		endcase
	endtask

	// Drop valid, wait for every outstanding result and for a clear sweep to
	// run out, so the core is idle afterwards.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		while (cyc < clear_cyc + MAX_PIXELS + 32)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_index_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_IMAGE_WIDTH: width_q = data[IWIDTH_W-1:0];
			CFG_PIXEL_COUNT: count_q = data[PCOUNT_W-1:0];
			CFG_ALLOW_REUSE: reuse_q = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] cnt,
			logic [CFG_W-1:0] reuse);
		drain();
		cfg_write(CFG_IMAGE_WIDTH, w);
		cfg_write(CFG_PIXEL_COUNT, cnt);
		cfg_write(CFG_ALLOW_REUSE, reuse);
	endtask

	// Shrink the scan range and load every entry in it before any query, so
	// no scan reads an entry that was never written. The last one is white.
	task automatic test_preload();
		program_regs(17'd320, CFG_W'(PRELOAD), 17'd0);
		for (int unsigned i = 0; i < PRELOAD - 1; i++)
			send_item(OP_LOAD, i[TAG_W-1:0], 8'($urandom_range(0, 127)),
				8'($urandom), 8'($urandom));
		send_item(OP_LOAD, TAG_W'(PRELOAD - 1), CHAN_MAX, CHAN_MAX, CHAN_MAX);
		send_item(OP_MATCH, 16'h0000, CHAN_MAX, CHAN_MAX, CHAN_MAX);
		program_regs(17'd0, CFG_W'(PRELOAD), 17'd1);
		send_item(OP_MATCH, 16'hFFFF, CHAN_MAX, CHAN_MAX, CHAN_MAX);
		program_regs(17'd2047, CFG_W'(PRELOAD), 17'd0);
		send_item(OP_MATCH, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_ties_and_reuse();
		program_regs(17'd3, 17'd8, 17'd0);
		send_item(OP_LOAD, 16'd0, 8'd0, 8'd0, 8'd0);
		send_item(OP_LOAD, 16'd1, CHAN_MAX, CHAN_MAX, CHAN_MAX);
		send_item(OP_LOAD, 16'd2, 8'd10, 8'd20, 8'd30);
		send_item(OP_LOAD, 16'd3, 8'd10, 8'd20, 8'd30);
		send_item(OP_LOAD, 16'd4, 8'd200, 8'd100, 8'd50);
		// equal distance: lowest index first, then the next unused one
		send_item(OP_MATCH, 16'd1, 8'd10, 8'd20, 8'd30);
		send_item(OP_MATCH, 16'd2, 8'd10, 8'd20, 8'd30);
		send_item(OP_MATCH, 16'd3, 8'd10, 8'd20, 8'd30);
		send_item(OP_LOAD, 16'd5, 8'd128, 8'd128, 8'd128);
		send_item(OP_UNUSED, 16'hFFFF, CHAN_MAX, CHAN_MAX, CHAN_MAX);
		send_item(OP_CLEAR, 16'd0, 8'd0, 8'd0, 8'd0);
		send_item(OP_MATCH, 16'd4, 8'd10, 8'd20, 8'd30);
		program_regs(17'd3, 17'd0, 17'd0);
		send_item(OP_MATCH, 16'd5, 8'd10, 8'd20, 8'd30);
		// black against white sits exactly at the limit and never qualifies
		program_regs(17'd3, 17'd1, 17'd1);
		send_item(OP_MATCH, 16'd6, CHAN_MAX, CHAN_MAX, CHAN_MAX);
		program_regs(17'd3, 17'd8, 17'd1);
		send_item(OP_MATCH, 16'd7, 8'd10, 8'd20, 8'd30);
		send_item(OP_MATCH, 16'd8, 8'd10, 8'd20, 8'd30);
		// every candidate used up, so the last query finds nothing
		program_regs(17'd3, 17'd2, 17'd0);
		send_item(OP_CLEAR, 16'd0, 8'd0, 8'd0, 8'd0);
		send_item(OP_MATCH, 16'd9, 8'd128, 8'd128, 8'd128);
		send_item(OP_MATCH, 16'd10, 8'd128, 8'd128, 8'd128);
		send_item(OP_MATCH, 16'd11, 8'd128, 8'd128, 8'd128);
	endtask

	task automatic test_row_extremes();
		send_item(OP_LOAD, 16'd29, CHAN_MAX, 8'd0, CHAN_MAX);
		program_regs(17'd1024, CFG_W'(PRELOAD), 17'd1);
		send_item(OP_MATCH, 16'd20, CHAN_MAX, 8'd0, CHAN_MAX);
		program_regs(17'd1025, CFG_W'(PRELOAD), 17'd0);
		send_item(OP_MATCH, 16'd21, CHAN_MAX, 8'd0, CHAN_MAX);
		program_regs(17'd7, CFG_W'(PRELOAD), 17'd0);
		send_item(OP_MATCH, 16'd22, 8'd60, 8'd200, 8'd10);
	endtask

	// Hold the result side off while queries keep coming, so the output
	// register and the finished scan both wait and the input stalls.
	task automatic test_backpressure();
		program_regs(17'd5, 17'd8, 17'd1);
		long_hold = 400;
		for (int k = 0; k < 10; k++)
			send_item(OP_MATCH, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		drain();
	endtask

	task automatic test_random();
		int unsigned       n_clear;
		int unsigned       pick;
		int unsigned       span;
		logic [CFG_W-1:0]  w;
		logic [COLOR_W-1:0] base;
		n_clear = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case ($urandom_range(0, 11))
				0: w = 17'd0;
				1: w = 17'd1;
				2: w = 17'd2;
				3: w = 17'd3;
				4: w = 17'd5;
				5: w = 17'd17;
				6: w = 17'd320;
				7: w = 17'd1023;
				8: w = 17'd1024;
				9: w = 17'd1025;
				10: w = 17'd2047;
				default: w = 17'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0: span = 0;
				1: span = 1;
				2: span = $urandom_range(2, 16);
				3: span = PRELOAD;
				default: span = $urandom_range(1, PRELOAD);
			endcase
			program_regs(w, span[CFG_W-1:0], 17'($urandom));
			tx_pace = ($urandom_range(0, 3) != 0);
			rx_pace = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < 10; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					if (span != 0 && pick < 30) begin
						base = cand_mem[$urandom_range(0, span - 1)];
						send_item(OP_MATCH, 16'($urandom), jitter(base[23:16]),
							jitter(base[15:8]), jitter(base[7:0]));
					end else begin
						send_item(OP_MATCH, 16'($urandom), 8'($urandom), 8'($urandom),
							8'($urandom));
					end
				end else if (pick < 85) begin
					send_item(OP_LOAD, (pick < 80) ? 16'($urandom_range(0, 63)) : 16'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
				end else if (pick < 92) begin
					send_item(OP_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
				end else if (pick < 96 && n_clear < 2) begin
					n_clear++;
					send_item(OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end else begin
					send_item(OP_MATCH, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				end
				if ($urandom_range(0, 15) == 0)
					drain();
			end
		end
		tx_pace = 1'b1;
		rx_pace = 1'b1;
	endtask

	// result side: random stall per beat, or one long hold when asked
	initial begin
		int unsigned wait_n;
		out_stall = 1'b0;
		forever begin
			if (long_hold != 0) begin
				wait_n = long_hold;
				long_hold = 0;
			end else begin
				wait_n = rx_pace ? $urandom_range(0, 6) : 0;
			end
			repeat (wait_n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall) && long_hold == 0);
		end
	end

	always @(posedge clk) begin
		match_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (match_found === 1'b1)
				n_found++;
			if (pending_matches.size() == 0) begin
				$error("result beat with no match query outstanding");
				err_count++;
			end else begin
				want = pending_matches.pop_front();
				compare_field("reference_tag", want.tag, reference_tag);
				compare_field("match_found", want.found, match_found);
				compare_field("match_index", want.index, match_index);
				compare_field("match_x", want.x, match_x);
				compare_field("match_y", want.y, match_y);
				compare_field("distance_squared", want.sq_dist, distance_squared);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: no beat for %0d cycles", quiet_cycles);
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_LOAD;
		pixel_index = '0;
		red         = '0;
		green       = '0;
		blue        = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_IMAGE_WIDTH;
		cfg_data    = '0;
		width_q     = IMAGE_WIDTH_RST;
		count_q     = PIXEL_COUNT_RST;
		reuse_q     = 1'b0;
		tx_pace     = 1'b1;
		rx_pace     = 1'b1;
		long_hold   = 0;
		cyc         = 0;
		clear_cyc   = 0;
		quiet_cycles = 0;
		err_count   = 0;
		n_items     = 0;
		n_results   = 0;
		n_found     = 0;
		foreach (used_mem[i])
			used_mem[i] = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the core sweeps its used marks after reset
		clear_cyc = cyc;

		test_preload();
		test_ties_and_reuse();
		test_row_extremes();
		test_backpressure();
		test_random();

		drain();
		repeat (64) @(posedge clk);
		$display("tb: %0d input beats taken, %0d result beats checked, %0d with a match",
			n_items, n_results, n_found);
		$display("tb: covered preloaded scans, ties, reuse, clears, width limits, hold-off");
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/gncm_pkg.sv
rtl/gncm_ram.sv
rtl/greedy_nearest_color_match_core.sv
dv/tb.sv
